FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Character codes, field widths and helpers for the SIP message framer.
// ----------------------------------------------------------------------------
`default_nettype none

package smf_pkg;

    localparam int unsigned DATA_W      = 8;
    localparam int unsigned BODY_LEN_W  = 24;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned M_TDATA_W   = 40;
    localparam int unsigned M_TUSER_W   = 3;

    localparam logic [BODY_LEN_W-1:0] MAX_BODY_RESET = '1;

    // result status codes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_NO_LENGTH = 2'd1;
    localparam status_t STATUS_SATURATED = 2'd2;

    // character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LOW_L = 8'h6C;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // "content-length"
    localparam int unsigned LONG_NAME_LEN = 14;
    localparam logic [IDX_W-1:0] NAME_LEN_IDX = IDX_W'(LONG_NAME_LEN);
    localparam logic [IDX_W-1:0] IDX_SAT      = '1;

    typedef logic [1:0] match_flags_t;
    localparam match_flags_t FLAGS_BOTH = 2'b11;
    localparam match_flags_t FLAG_SHORT = 2'b01;
    localparam match_flags_t FLAG_LONG  = 2'b10;

    function automatic logic [7:0] long_name_char(input logic [IDX_W-1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h6C; // l
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_lws(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_HT) || (b == CH_VT) || (b == CH_FF);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return is_lws(b) || (b == CH_CR) || (b == CH_LF);
    endfunction

    // One header-name character: returns {flags, index}.
    function automatic logic [IDX_W+1:0] name_step(input match_flags_t flags,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [7:0] b);
        logic [7:0]         c;
        match_flags_t       f;
        logic [IDX_W-1:0]   i;
        c = ((b >= CH_UP_A) && (b <= CH_UP_Z)) ? b + CASE_OFS : b;
        f = flags;
        i = idx;
        if ((idx >= NAME_LEN_IDX) || (c != long_name_char(idx))) begin
            f = f & FLAG_SHORT;
        end
        if ((idx != '0) || (c != CH_LOW_L)) begin
            f = f & FLAG_LONG;
        end
        if (idx != IDX_SAT) begin
            i = idx + 1'b1;
        end
        return {f, i};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sip_message_framer.sv
// ----------------------------------------------------------------------------
// sip_message_framer
// Marks SIP message boundaries in a TCP byte stream using Content-Length.
//
// s_ channel: one stream byte per beat. m_ channel: the same byte plus flags,
// one result beat per input beat, in order. cfg channel: max_body_length is to be
// written only while no message is in flight; the block does not enforce this,
// and cfg_ready is always high. An accepted input beat passes through the input
// register, then the result register fed by the per-byte parser update. Throughput:
// one byte per cycle while m_tready is high; the parser state update is a single pass
// whose longest path is the accumulate (acc * 10 + digit) and limit compare.
// Stall: when m_tready is low the result register holds and the input
// register fills, then s_tready drops; nothing is dropped or repeated.
// Reset (aresetn low, synchronous): parser returns to idle between messages,
// both stages empty, max_body_length back to all ones.
// m_tlast marks the last byte of a message; body length and status in tdata
// are only nonzero on that beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_message_framer
    import smf_pkg::*;
#(
    parameter int unsigned LENGTH_WIDTH = 24
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // config write
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [BODY_LEN_W-1:0]  cfg_data,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [DATA_W-1:0]      s_tdata,   // [7:0] data_byte
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,   // [7:0] out_byte, [31:8] body_length,
                                                   // [33:32] status, [39:34] zero
    output logic [M_TUSER_W-1:0]        m_tuser,   // [0] keep, [1] start_of_message,
                                                   // [2] in_body
    output logic                        m_tlast    // end_of_message
);

    localparam int unsigned LW = LENGTH_WIDTH;
    localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_WIDTH) - 64'd1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_NAME,
        PH_NAME_WS,
        PH_SKIP,
        PH_LEN,
        PH_BODY
    } phase_t;

    // value-field sub-state kept in the name index
    localparam logic [IDX_W-1:0] LEN_LEAD = 4'd0;
    localparam logic [IDX_W-1:0] LEN_DIG  = 4'd1;
    localparam logic [IDX_W-1:0] LEN_STOP = 4'd2;

    // blank line progress codes
    localparam logic [1:0] BL_NONE = 2'd0;
    localparam logic [1:0] BL_CR   = 2'd1;
    localparam logic [1:0] BL_CRLF = 2'd2;
    localparam logic [1:0] BL_CR2  = 2'd3;

    // ---------------- registers ----------------
    logic [BODY_LEN_W-1:0]  max_len_reg;
    logic                   in_vld_reg;
    logic [DATA_W-1:0]      in_byte_reg;

    phase_t                 phase_reg,   phase_next;
    logic [IDX_W-1:0]       idx_reg,     idx_next;
    match_flags_t           flags_reg,   flags_next;
    logic [LW-1:0]          acc_reg,     acc_next;
    logic                   found_reg,   found_next;
    logic [1:0]             blp_reg,     blp_next;
    logic [LW-1:0]          rem_reg,     rem_next;
    status_t                sh_reg,      sh_next;

    logic                   out_vld_reg;
    logic [DATA_W-1:0]      out_byte_reg;
    logic                   keep_reg,    keep_next;
    logic                   sop_reg,     sop_next;
    logic                   body_reg,    body_next;
    logic                   eom_reg,     eom_next;
    logic [BODY_LEN_W-1:0]  blen_reg,    blen_next;
    status_t                status_reg,  status_next;

    // ---------------- handshake ----------------
    logic advance;
    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    // ---------------- datapath helpers ----------------
    logic [7:0]       b;
    logic             eol;
    logic [31:0]      cfg_ext;
    logic [LW-1:0]    lim;
    logic [LW+3:0]    acc_x10;
    logic [IDX_W+1:0] nstep;
    logic [IDX_W+1:0] nstep_clr;
    logic             hit;

    assign b   = in_byte_reg;
    assign eol = (b == CH_CR) || (b == CH_LF);

    // saturation limit: smaller of the register and the accumulator range
    assign cfg_ext = 32'(max_len_reg);
    assign lim     = (cfg_ext > LEN_MASK) ? LW'(LEN_MASK) : LW'(cfg_ext);

    // acc * 10 + digit as two shifts and two adds
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                   + (LW+4)'(b - CH_ZERO);

    assign nstep     = name_step(flags_reg, idx_reg, b);
    assign nstep_clr = name_step('0, idx_reg, b);

    assign hit = (flags_reg[0] && (idx_reg == 4'd1)) ||
                 (flags_reg[1] && (idx_reg == NAME_LEN_IDX));

    // ---------------- per-byte parser update ----------------
    always_comb begin
        logic finish;
        logic line_done;

        phase_next  = phase_reg;
        idx_next    = idx_reg;
        flags_next  = flags_reg;
        acc_next    = acc_reg;
        found_next  = found_reg;
        blp_next    = blp_reg;
        rem_next    = rem_reg;
        sh_next     = sh_reg;

        keep_next   = 1'b1;
        sop_next    = 1'b0;
        body_next   = 1'b0;
        eom_next    = 1'b0;
        blen_next   = '0;
        status_next = STATUS_OK;

        finish      = 1'b0;
        line_done   = 1'b0;

        if (phase_reg == PH_IDLE) begin
            if (is_space(b)) begin
                keep_next = 1'b0;
            end else begin
                sop_next   = 1'b1;
                phase_next = PH_START;
                idx_next   = '0;
                flags_next = FLAGS_BOTH;
                acc_next   = '0;
                found_next = 1'b0;
                blp_next   = BL_NONE;
                rem_next   = '0;
                sh_next    = STATUS_OK;
            end
        end else if (phase_reg == PH_BODY) begin
            body_next = 1'b1;
            rem_next  = rem_reg - LW'(rem_reg != '0);
            if (rem_next == '0) begin
                finish = 1'b1;
            end
        end else begin
            // blank line tracking: CR LF CR LF ends the header block
            priority if (b == CH_CR) begin
                blp_next = (blp_reg == BL_CRLF) ? BL_CR2 : BL_CR;
            end else if ((b == CH_LF) && (blp_reg == BL_CR)) begin
                blp_next = BL_CRLF;
            end else if ((b == CH_LF) && (blp_reg == BL_CR2)) begin
                blp_next  = BL_NONE;
                line_done = 1'b1;
                if (found_reg && (acc_reg != '0)) begin
                    rem_next   = acc_reg;
                    phase_next = PH_BODY;
                end else begin
                    finish = 1'b1;
                end
            end else begin
                blp_next = BL_NONE;
            end

            if (!line_done) begin
                if (eol) begin
                    phase_next = PH_NAME;
                    idx_next   = '0;
                    flags_next = FLAGS_BOTH;
                end else begin
                    unique case (phase_reg)
                        PH_START, PH_SKIP: begin
                        end
                        PH_NAME: begin
                            if (b == CH_COLON) begin
                                if (hit && !found_reg) begin
                                    found_next = 1'b1;
                                    acc_next   = '0;
                                    idx_next   = LEN_LEAD;
                                    phase_next = PH_LEN;
                                end else begin
                                    phase_next = PH_SKIP;
                                end
                            end else if (is_lws(b)) begin
                                if (idx_reg != '0) begin
                                    phase_next = PH_NAME_WS;
                                end
                            end else begin
                                flags_next = nstep[IDX_W+1:IDX_W];
                                idx_next   = nstep[IDX_W-1:0];
                            end
                        end
                        PH_NAME_WS: begin
                            if (b == CH_COLON) begin
                                if (hit && !found_reg) begin
                                    found_next = 1'b1;
                                    acc_next   = '0;
                                    idx_next   = LEN_LEAD;
                                    phase_next = PH_LEN;
                                end else begin
                                    phase_next = PH_SKIP;
                                end
                            end else if (!is_lws(b)) begin
                                // whitespace inside the name: no match possible
                                flags_next = nstep_clr[IDX_W+1:IDX_W];
                                idx_next   = nstep_clr[IDX_W-1:0];
                                phase_next = PH_NAME;
                            end
                        end
                        PH_LEN: begin
                            if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
                                if (idx_reg <= LEN_DIG) begin
                                    idx_next = LEN_DIG;
                                    if (acc_x10 > (LW+4)'(lim)) begin
                                        acc_next = lim;
                                        sh_next  = STATUS_SATURATED;
                                    end else begin
                                        acc_next = acc_x10[LW-1:0];
                                    end
                                end
                            end else if (!(is_lws(b) && (idx_reg == LEN_LEAD))) begin
                                idx_next = LEN_STOP;
                            end
                        end
                        default: begin
                            phase_next = PH_SKIP;
                        end
                    endcase
                end
            end
        end

        if (finish) begin
            eom_next    = 1'b1;
            blen_next   = BODY_LEN_W'(acc_reg);
            status_next = found_reg ? sh_reg : STATUS_NO_LENGTH;
            phase_next  = PH_IDLE;
            idx_next    = '0;
            flags_next  = FLAGS_BOTH;
            acc_next    = '0;
            found_next  = 1'b0;
            blp_next    = BL_NONE;
            rem_next    = '0;
            sh_next     = STATUS_OK;
        end
    end

    // ---------------- state and output registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_BODY_RESET;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= PH_IDLE;
            idx_reg     <= '0;
            flags_reg   <= FLAGS_BOTH;
            acc_reg     <= '0;
            found_reg   <= 1'b0;
            blp_reg     <= BL_NONE;
            rem_reg     <= '0;
            sh_reg      <= STATUS_OK;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_len_reg <= cfg_data;
            end

            if (s_tvalid && s_tready) begin
                in_vld_reg  <= 1'b1;
                in_byte_reg <= s_tdata;
            end else if (advance) begin
                in_vld_reg  <= 1'b0;
            end

            if (advance) begin
                out_vld_reg  <= 1'b1;
                out_byte_reg <= b;
                keep_reg     <= keep_next;
                sop_reg      <= sop_next;
                body_reg     <= body_next;
                eom_reg      <= eom_next;
                blen_reg     <= blen_next;
                status_reg   <= status_next;

                phase_reg    <= phase_next;
                idx_reg      <= idx_next;
                flags_reg    <= flags_next;
                acc_reg      <= acc_next;
                found_reg    <= found_next;
                blp_reg      <= blp_next;
                rem_reg      <= rem_next;
                sh_reg       <= sh_next;
            end else if (m_tready) begin
                out_vld_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, status_reg, blen_reg, out_byte_reg};
    assign m_tuser  = {body_reg, sop_reg, keep_reg};
    assign m_tlast  = eom_reg;

    // ---------------- assertions ----------------
`include "assert_macros.svh"

    // a body is only entered with bytes left to count
    `ASSERT_IMPL(a_body_nonempty, phase_reg == PH_BODY, rem_reg != '0)
    // the length never passes the saturation limit
    `ASSERT_IMPL(a_acc_limit, phase_reg != PH_IDLE, acc_reg <= lim)
    // dropped whitespace carries no message flags
    `ASSERT_IMPL(a_drop_clean, out_vld_reg && !keep_reg,
                 !sop_reg && !body_reg && !eom_reg)
    // length and status only travel with the end of a message
    `ASSERT_IMPL(a_len_on_eom, out_vld_reg && !eom_reg,
                 blen_reg == '0 && status_reg == STATUS_OK)
    // a finished message leaves the parser idle and cleared
    `ASSERT_NEXT(a_eom_idle, advance && eom_next,
                 phase_reg == PH_IDLE && acc_reg == '0 && !found_reg)

endmodule

`default_nettype wire
